/* sv/alacp_pkg.sv */
// Shared types and constants for the uncompressed ALAC frame packer.
// No dependencies; compiled before every module of the block.
package alacp_pkg;

    // Configuration register
    localparam int CFG_W                = 13;
    localparam int MAX_BLOCK_FRAMES_DEF = 4096;
    localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET = 13'd352;

    // One stereo frame on the input channel
    typedef struct packed {
        logic              kind;          // 0 = audio, 1 = pad (zero samples)
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } alacp_in_t;

    // One packet byte on the output channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_packet;
        logic       last;
    } alacp_out_t;

    // Classified frame handed from the front end to the byte emitter
    typedef struct packed {
        logic             first;   // frame opens a packet: header goes first
        logic             close;   // frame closes a packet: tail and end tag follow
        logic [CFG_W-1:0] size;    // block size in use, for the header
        logic [7:0]       held;    // previous frame's last byte, low bit still open
        logic [15:0]      left;
        logic [15:0]      right;
    } alacp_cmd_t;

endpackage

/* sv/alacp_front.sv */
// Front end of the packer: holds the block size register, counts frames
// within a packet and classifies each accepted frame. Uses alacp_pkg.
module alacp_front #(
    parameter int MAX_BLOCK_FRAMES = alacp_pkg::MAX_BLOCK_FRAMES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [alacp_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  alacp_pkg::alacp_in_t       s_data,
    output logic                       push_valid,
    input  logic                       push_ready,
    output alacp_pkg::alacp_cmd_t      push_cmd
);
    import alacp_pkg::*;

    logic [CFG_W-1:0] block_size_reg, block_size_next;
    logic [CFG_W-1:0] frame_idx_reg, frame_idx_next;
    logic [7:0]       held_reg, held_next;
    logic [CFG_W-1:0] size_in_use;
    logic [15:0]      left, right;
    logic             close;
    logic             accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    // Clamp the block size to 1 .. MAX_BLOCK_FRAMES
    always_comb begin
        if (block_size_reg == '0) begin
            size_in_use = CFG_W'(1);
        end else if (32'(block_size_reg) > 32'(MAX_BLOCK_FRAMES)) begin
            size_in_use = CFG_W'(MAX_BLOCK_FRAMES);
        end else begin
            size_in_use = block_size_reg;
        end
    end

    // Classify the frame; pad frames carry zero samples
    always_comb begin
        left  = s_data.kind ? 16'h0000 : s_data.left_sample;
        right = s_data.kind ? 16'h0000 : s_data.right_sample;
        close = ({1'b0, frame_idx_reg} + (CFG_W+1)'(1)) >= {1'b0, size_in_use};

        push_cmd.first = (frame_idx_reg == '0);
        push_cmd.close = close;
        push_cmd.size  = size_in_use;
        push_cmd.held  = held_reg;
        push_cmd.left  = left;
        push_cmd.right = right;
    end

    // Packet position state
    always_comb begin
        block_size_next = cfg_we ? cfg_wdata : block_size_reg;
        frame_idx_next  = frame_idx_reg;
        held_next       = held_reg;
        if (accept) begin
            if (close) begin
                frame_idx_next = '0;
                held_next      = 8'h00;
            end else begin
                frame_idx_next = frame_idx_reg + CFG_W'(1);
                held_next      = {right[6:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= BLOCK_SIZE_RESET;
            frame_idx_reg  <= '0;
            held_reg       <= 8'h00;
        end else begin
            block_size_reg <= block_size_next;
            frame_idx_reg  <= frame_idx_next;
            held_reg       <= held_next;
        end
    end

    // Held byte is clear whenever a packet is about to open
    assert property (@(posedge aclk) disable iff (!aresetn)
        (frame_idx_reg == '0) |-> (held_reg == 8'h00))
        else $error("held byte not clear at packet start");

endmodule

/* sv/alacp_cmd_fifo.sv */
// Two-entry queue of classified frames between front end and byte emitter.
// Uses alacp_pkg for the command type.
module alacp_cmd_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  alacp_pkg::alacp_cmd_t push_cmd,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output alacp_pkg::alacp_cmd_t pop_cmd
);
    import alacp_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    alacp_cmd_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

/* sv/alacp_back.sv */
// Byte emitter of the packer: walks each classified frame byte by byte
// into a registered output stage. Uses alacp_pkg.
module alacp_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  alacp_pkg::alacp_cmd_t pop_cmd,
    output logic                  m_valid,
    input  logic                  m_ready,
    output alacp_pkg::alacp_out_t m_data
);
    import alacp_pkg::*;

    // Byte positions within one frame's output; non-opening frames start at POS_JOIN
    typedef logic [3:0] pos_t;
    localparam pos_t POS_HDR_ELEM  = 4'd0;
    localparam pos_t POS_HDR_ZERO  = 4'd1;
    localparam pos_t POS_HDR_FLAGS = 4'd2;
    localparam pos_t POS_SIZE_HI   = 4'd3;
    localparam pos_t POS_SIZE_MID  = 4'd4;
    localparam pos_t POS_SIZE_LO   = 4'd5;
    localparam pos_t POS_JOIN      = 4'd6;
    localparam pos_t POS_LEFT_HI   = 4'd7;
    localparam pos_t POS_MIX       = 4'd8;
    localparam pos_t POS_RIGHT_HI  = 4'd9;
    localparam pos_t POS_TAIL      = 4'd10;
    localparam pos_t POS_END       = 4'd11;

    localparam logic [7:0] ELEM_STEREO  = 8'h20;
    localparam logic [7:0] ESCAPE_FLAGS = 8'h12;
    localparam logic [7:0] END_TAG      = 8'hC0;

    alacp_cmd_t cmd_reg, cmd_next;
    pos_t       pos_reg, pos_next;
    logic       busy_reg, busy_next;
    logic       m_valid_reg, m_valid_next;
    alacp_out_t m_data_reg, m_data_next;

    logic       load, advance, pos_last, take;
    logic [31:0] size32;
    logic        left_top;
    logic [7:0]  cur_byte;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign load      = !m_valid_reg || m_ready;
    assign advance   = busy_reg && load;
    assign pos_last  = ((pos_reg == POS_RIGHT_HI) && !cmd_reg.close) || (pos_reg == POS_END);
    assign pop_ready = !busy_reg || (advance && pos_last);
    assign take      = pop_valid && pop_ready;

    assign size32   = 32'(cmd_reg.size);
    assign left_top = cmd_reg.left[15];

    // Byte select for the current position
    always_comb begin
        case (pos_reg)
            POS_HDR_ELEM:  cur_byte = ELEM_STEREO;
            POS_HDR_ZERO:  cur_byte = 8'h00;
            POS_HDR_FLAGS: cur_byte = ESCAPE_FLAGS | {7'b0, size32[31]};
            POS_SIZE_HI:   cur_byte = size32[30:23];
            POS_SIZE_MID:  cur_byte = size32[22:15];
            POS_SIZE_LO:   cur_byte = size32[14:7];
            POS_JOIN:      cur_byte = cmd_reg.first ? {size32[6:0], left_top}
                                                    : (cmd_reg.held | {7'b0, left_top});
            POS_LEFT_HI:   cur_byte = cmd_reg.left[14:7];
            POS_MIX:       cur_byte = {cmd_reg.left[6:0], cmd_reg.right[15]};
            POS_RIGHT_HI:  cur_byte = cmd_reg.right[14:7];
            POS_TAIL:      cur_byte = {cmd_reg.right[6:0], 1'b1};
            POS_END:       cur_byte = END_TAG;
            default:       cur_byte = 8'h00;
        endcase
    end

    // Sequencer over the current frame, plus output stage
    always_comb begin
        cmd_next     = cmd_reg;
        pos_next     = pos_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (take) begin
            cmd_next  = pop_cmd;
            busy_next = 1'b1;
            pos_next  = pop_cmd.first ? POS_HDR_ELEM : POS_JOIN;
        end else if (advance && pos_last) begin
            busy_next = 1'b0;
        end else if (advance) begin
            pos_next = pos_reg + 4'd1;
        end

        if (load) begin
            m_valid_next              = advance;
            m_data_next.out_byte      = cur_byte;
            m_data_next.end_of_packet = (pos_reg == POS_END);
            m_data_next.last          = pos_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.end_of_packet) |-> m_data_reg.last)
        else $error("end of packet not on last byte of frame");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.end_of_packet) |-> (m_data_reg.out_byte == END_TAG))
        else $error("end of packet byte is not the end tag");

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pos_reg <= POS_END && (cmd_reg.first || pos_reg >= POS_JOIN)))
        else $error("byte position outside the frame");

endmodule

/* sv/alac_uncompressed_frame_packer.sv */
// Uncompressed ALAC packet packer, stereo 16-bit, one byte per transaction.
// Top level: front end, command queue and byte emitter. Uses alacp_pkg.
//
// Input channel s_*: one stereo frame per transaction (kind, left, right);
// a pad frame is coded as two zero samples. Output channel m_*: packet bytes,
// with end_of_packet on the closing end tag byte and last on the final byte
// caused by each frame. cfg_we/cfg_wdata write the block size (frames per
// packet, also placed in the header); values are clamped to 1..MAX_BLOCK_FRAMES.
//
// Each frame yields 4 bytes, 10 when it opens a packet, plus 2 when it closes
// one. The byte emitter sends one byte per cycle while m_ready is high and a
// frame is waiting. An idle emitter loads a queued frame into its command
// register, and its first byte into the output register. A two-entry queue
// sits between the front end and the emitter, so new frames are taken while
// earlier bytes are still going out. A stall on m_ready freezes the output
// register; the queue then fills and s_ready drops.
// Reset clears the frame count (next frame opens a packet), the held byte,
// the queue and the output stage, and loads a block size of 352.
module alac_uncompressed_frame_packer #(
    parameter int MAX_BLOCK_FRAMES = alacp_pkg::MAX_BLOCK_FRAMES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [alacp_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  alacp_pkg::alacp_in_t        s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output alacp_pkg::alacp_out_t       m_data
);
    import alacp_pkg::*;

    logic       push_valid, push_ready;
    alacp_cmd_t push_cmd;
    logic       pop_valid, pop_ready;
    alacp_cmd_t pop_cmd;

    alacp_front #(
        .MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    alacp_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    alacp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* bench/alac_uncompressed_frame_packer_tb.sv */
// Self-checking bench for alac_uncompressed_frame_packer: random idling on both
// channels, block size changes while the packer is idle, bytewise packet checks.
// Depends on alacp_pkg and the packer RTL; needs no files or arguments.
module alac_uncompressed_frame_packer_tb;
    import alacp_pkg::*;

    localparam logic KIND_AUDIO = 1'b0;
    localparam logic KIND_PAD   = 1'b1;

    localparam logic [7:0] HDR_ELEMENT = 8'h20;   // stereo element tag
    localparam logic [7:0] HDR_SPARE   = 8'h00;
    localparam logic [7:0] HDR_FLAGS   = 8'h12;   // partial-frame and escape flags
    localparam logic [7:0] END_TAG     = 8'hC0;   // end tag 111, its first bit in the byte before

    localparam int unsigned SIZE_CEIL = MAX_BLOCK_FRAMES_DEF;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    alacp_in_t        s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    alacp_out_t       m_data;

    // Frames waiting to be sent, and packet bytes still owed by the packer
    alacp_in_t  pending_frames[$];
    alacp_out_t byte_expect[$];

    // Packer state as predicted by the bench
    logic [CFG_W-1:0] block_size_reg = BLOCK_SIZE_RESET;
    int unsigned      pkt_frames     = 0;
    logic [7:0]       held_tail      = 8'h00;

    int  fail_count = 0;
    bit  quiet_tail = 1'b0;    // no idling in the last stretch of the run

    alac_uncompressed_frame_packer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic alacp_out_t mk_byte(input logic [7:0] b, input logic eop);
        alacp_out_t o;
        o.out_byte      = b;
        o.end_of_packet = eop;
        o.last          = 1'b0;
        return o;
    endfunction

    // Work out the bytes one accepted frame produces and advance the packet state
    function automatic void pack_frame(input alacp_in_t f);
        logic [15:0] l;
        logic [15:0] r;
        int unsigned used;
        alacp_out_t  seq[$];
        l = (f.kind == KIND_PAD) ? 16'h0000 : f.left_sample;
        r = (f.kind == KIND_PAD) ? 16'h0000 : f.right_sample;
        used = 32'(block_size_reg);
        if (used < 1) used = 1;
        if (used > SIZE_CEIL) used = SIZE_CEIL;

        // header on the first frame, otherwise finish the held byte
        if (pkt_frames == 0) begin
            seq.push_back(mk_byte(HDR_ELEMENT, 1'b0));
            seq.push_back(mk_byte(HDR_SPARE, 1'b0));
            seq.push_back(mk_byte(HDR_FLAGS | 8'(used >> 31), 1'b0));
            seq.push_back(mk_byte(8'(used >> 23), 1'b0));
            seq.push_back(mk_byte(8'(used >> 15), 1'b0));
            seq.push_back(mk_byte(8'(used >> 7), 1'b0));
            seq.push_back(mk_byte({used[6:0], l[15]}, 1'b0));
        end else begin
            seq.push_back(mk_byte(held_tail | {7'd0, l[15]}, 1'b0));
        end

        // samples, shifted by one bit
        seq.push_back(mk_byte(l[14:7], 1'b0));
        seq.push_back(mk_byte({l[6:0], r[15]}, 1'b0));
        seq.push_back(mk_byte(r[14:7], 1'b0));

        // packet close: final sample byte with low bit set, then end tag
        if (pkt_frames + 1 >= used) begin
            seq.push_back(mk_byte({r[6:0], 1'b1}, 1'b0));
            seq.push_back(mk_byte(END_TAG, 1'b1));
            pkt_frames = 0;
            held_tail  = 8'h00;
        end else begin
            held_tail  = {r[6:0], 1'b0};
            pkt_frames = pkt_frames + 1;
        end

        seq[seq.size()-1].last = 1'b1;
        foreach (seq[i]) byte_expect.push_back(seq[i]);
    endfunction

    // Input driver: one transaction at a time from pending_frames, random gaps
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                pack_frame(s_data);
                if (!quiet_tail && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 18);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_frames.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_frames.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output ready: short random stalls, plus at most two long hold-offs to back up the input
    int stall_left = 0;
    int hold_left  = 0;
    int long_holds = 0;
    int bytes_out  = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) bytes_out = bytes_out + 1;
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready   <= 1'b0;
            end else if (!quiet_tail && long_holds < 2 && pending_frames.size() > 4 &&
                         bytes_out >= 250 * (long_holds + 1)) begin
                long_holds = long_holds + 1;
                hold_left  = 200;
                m_ready    <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 18);
            end
        end
    end

    // Output monitor: compare each byte transaction with the oldest expected byte
    always @(posedge aclk) begin
        alacp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (byte_expect.size() == 0) begin
                $error("unexpected byte 0x%02h with nothing outstanding", m_data.out_byte);
                fail_count = fail_count + 1;
            end else begin
                want = byte_expect.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected 0x%02h, got 0x%02h",
                           want.out_byte, m_data.out_byte);
                    fail_count = fail_count + 1;
                end
                if (m_data.end_of_packet !== want.end_of_packet) begin
                    $error("end_of_packet: expected %0b, got %0b",
                           want.end_of_packet, m_data.end_of_packet);
                    fail_count = fail_count + 1;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_data.last);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    function automatic void queue_frame(input logic k, input logic [15:0] l,
                                        input logic [15:0] r);
        alacp_in_t f;
        f.kind         = k;
        f.left_sample  = l;
        f.right_sample = r;
        pending_frames.push_back(f);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void queue_random(input int n);
        for (int i = 0; i < n; i++)
            queue_frame(($urandom_range(0, 5) == 0) ? KIND_PAD : KIND_AUDIO,
                        pick_sample(), pick_sample());
    endfunction

    // Wait until every frame is taken and every owed byte has come out
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_frames.size() != 0 || s_valid || byte_expect.size() != 0);
    endtask

    // Block size write, only ever issued while the packer is idle
    task automatic write_block_size(input logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        block_size_reg = v;
        @(negedge aclk);
    endtask

    // Stimulus
    initial begin
        int         random_items;
        int         n;
        int         sel;
        logic [CFG_W-1:0] sz;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset block size, packet left open; sample extremes, pad with junk fields
        queue_frame(KIND_AUDIO, 16'h7FFF, 16'h8000);
        queue_frame(KIND_AUDIO, 16'h8000, 16'h7FFF);
        queue_frame(KIND_AUDIO, 16'h0000, 16'h0000);
        queue_frame(KIND_AUDIO, 16'hFFFF, 16'hFFFF);
        queue_frame(KIND_PAD,   16'h1234, 16'hFFFF);
        queue_frame(KIND_AUDIO, 16'h5555, 16'hAAAA);
        wait_drained();

        // shrink below the count mid-packet: next frame closes it
        write_block_size(13'd2);
        queue_frame(KIND_AUDIO, 16'hAAAA, 16'h5555);
        queue_frame(KIND_AUDIO, 16'h8001, 16'h7FFE);
        queue_frame(KIND_PAD,   16'hFFFF, 16'hFFFF);
        wait_drained();

        // zero is taken as one: every frame is a packet
        write_block_size(13'd0);
        queue_frame(KIND_AUDIO, 16'hFFFF, 16'hFFFF);
        queue_frame(KIND_PAD,   16'h8000, 16'h8000);
        wait_drained();
        write_block_size(13'd1);
        queue_frame(KIND_AUDIO, 16'h8000, 16'h7FFF);
        wait_drained();

        // oversize clamps to the maximum; then maximum, then close with one
        write_block_size(13'h1FFF);
        queue_frame(KIND_AUDIO, 16'h0F0F, 16'hF0F0);
        queue_frame(KIND_AUDIO, 16'hFFFF, 16'h0000);
        wait_drained();
        write_block_size(13'd4096);
        queue_frame(KIND_AUDIO, 16'h0000, 16'hFFFF);
        wait_drained();
        write_block_size(13'd1);
        queue_frame(KIND_AUDIO, 16'h7FFF, 16'h7FFF);
        wait_drained();

        // random phases, mostly small packets, size changes between phases
        random_items = 0;
        while (random_items < 120) begin
            if ($urandom_range(0, 3) != 0) begin
                sel = $urandom_range(0, 9);
                if (sel < 7)      sz = CFG_W'($urandom_range(0, 8));
                else if (sel < 9) sz = CFG_W'($urandom_range(9, 40));
                else              sz = CFG_W'($urandom_range(0, 8191));
                write_block_size(sz);
            end
            n = $urandom_range(6, 24);
            queue_random(n);
            random_items = random_items + n;
            wait_drained();
        end

        // last stretch at full rate on both sides
        quiet_tail = 1'b1;
        write_block_size(13'd3);
        queue_random(20);
        wait_drained();

        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("alac_uncompressed_frame_packer_tb: PASS");
        end else begin
            $display("alac_uncompressed_frame_packer_tb: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("alac_uncompressed_frame_packer_tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/alacp_pkg.sv
sv/alacp_front.sv
sv/alacp_cmd_fifo.sv
sv/alacp_back.sv
sv/alac_uncompressed_frame_packer.sv
bench/alac_uncompressed_frame_packer_tb.sv
